FILE: sv/pma_pkg.sv
// ----------------------------------------------------------------------------
// pma_pkg
// Shared types, constants and command codes of the piece motion animator.
// ----------------------------------------------------------------------------
`default_nettype none

package pma_pkg;

    // Default piece count and fixed axis count
    localparam int PIECES_DEF = 64;
    localparam int NUM_AXES   = 3;

    // Item modes
    localparam logic [3:0] MODE_TICK      = 4'd0;
    localparam logic [3:0] MODE_MOVE      = 4'd1;
    localparam logic [3:0] MODE_MOVE_NOW  = 4'd2;
    localparam logic [3:0] MODE_TURN      = 4'd3;
    localparam logic [3:0] MODE_TURN_NOW  = 4'd4;
    localparam logic [3:0] MODE_SPIN      = 4'd5;
    localparam logic [3:0] MODE_STOP_SPIN = 4'd6;
    localparam logic [3:0] MODE_SHOW      = 4'd7;
    localparam logic [3:0] MODE_HIDE      = 4'd8;

    // Axis flag bits
    localparam int FLAG_MOVE = 0;
    localparam int FLAG_TURN = 1;

    // One stored row per piece axis
    typedef struct packed {
        logic signed [31:0] lin_pos;
        logic signed [31:0] lin_goal;
        logic signed [31:0] lin_speed;
        logic [31:0]        rot_pos;
        logic [31:0]        rot_goal;
        logic [31:0]        rot_speed;
        logic signed [47:0] spin_now;
        logic signed [47:0] spin_goal;
        logic [31:0]        spin_ramp;
        logic [1:0]         flags;
    } t_row;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISP,
        ST_SW_RD,
        ST_SW_MUL,
        ST_SW_APP,
        ST_SW_ADV,
        ST_SW_WR,
        ST_CM_RD,
        ST_CM_EX,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic cnt_inc;
        logic clr_wr;
        logic sw_rd;
        logic sw_mul;
        logic sw_app;
        logic sw_adv;
        logic sw_wr;
        logic still_clr;
        logic pend_upd;
        logic cm_rd;
        logic cm_ex;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic pending;
        logic last;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: sv/pma_if.sv
// ----------------------------------------------------------------------------
// pma_if
// Valid/ready channels of the piece motion animator: items in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pma_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         mode;
    logic [5:0]         piece;
    logic [1:0]         axis;
    logic signed [31:0] goal;
    logic signed [31:0] rate;
    logic [15:0]        elapsed;

    modport source (output valid, mode, piece, axis, goal, rate, elapsed, input ready);
    modport sink   (input valid, mode, piece, axis, goal, rate, elapsed, output ready);
endinterface

interface pma_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic [31:0]        angle;
    logic               moving;
    logic               turning;
    logic               shown;
    logic               any_motion;

    modport source (output valid, position, angle, moving, turning, shown, any_motion,
                    input ready);
    modport sink   (input valid, position, angle, moving, turning, shown, any_motion,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/pma_ctrl.sv
// ----------------------------------------------------------------------------
// pma_ctrl
// Sequencer: clearing pass, dispatch, per-slot sweep steps, command execute.
// ----------------------------------------------------------------------------
`default_nettype none

module pma_ctrl
    import pma_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                o_cmd.cnt_clr   = 1'b1;
                o_cmd.still_clr = 1'b1;
                n_state = (i_sts.is_tick && i_sts.pending) ? ST_SW_RD : ST_CM_RD;
            end
            ST_SW_RD: begin
                o_cmd.sw_rd = 1'b1;
                n_state     = ST_SW_MUL;
            end
            ST_SW_MUL: begin
                o_cmd.sw_mul = 1'b1;
                n_state      = ST_SW_APP;
            end
            ST_SW_APP: begin
                o_cmd.sw_app = 1'b1;
                n_state      = ST_SW_ADV;
            end
            ST_SW_ADV: begin
                o_cmd.sw_adv = 1'b1;
                n_state      = ST_SW_WR;
            end
            ST_SW_WR: begin
                o_cmd.sw_wr   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.last) begin
                    o_cmd.pend_upd = 1'b1;
                    n_state        = ST_CM_RD;
                end else begin
                    n_state = ST_SW_RD;
                end
            end
            ST_CM_RD: begin
                o_cmd.cm_rd = 1'b1;
                n_state     = ST_CM_EX;
            end
            ST_CM_EX: begin
                o_cmd.cm_ex = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/pma_dp.sv
// ----------------------------------------------------------------------------
// pma_dp
// Datapath: slot memory, step multipliers, approach logic, flags, results.
// ----------------------------------------------------------------------------
`default_nettype none

module pma_dp
    import pma_pkg::*;
#(
    parameter int PIECES = PIECES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [3:0]         i_mode,
    input  wire logic [5:0]         i_piece,
    input  wire logic [1:0]         i_axis,
    input  wire logic signed [31:0] i_goal,
    input  wire logic signed [31:0] i_rate,
    input  wire logic [15:0]        i_elapsed,
    output t_dp_sts                 o_sts,
    output logic signed [31:0]      o_position,
    output logic [31:0]             o_angle,
    output logic                    o_moving,
    output logic                    o_turning,
    output logic                    o_shown,
    output logic                    o_any_motion
);

    localparam int SLOTS  = PIECES * NUM_AXES;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PIDX_W = (PIECES > 1) ? $clog2(PIECES) : 1;

    // Latched item
    logic [3:0]         r_mode;
    logic [5:0]         r_piece;
    logic signed [31:0] r_goal;
    logic signed [31:0] r_rate;
    logic [15:0]        r_el;
    logic [SLOT_W-1:0]  r_idx;
    logic               r_ok;
    logic               r_pok;

    logic [13:0]        piece_ext;
    logic [15:0]        idx_full;
    logic               pok, ok;

    assign piece_ext = {8'd0, i_piece};
    assign idx_full  = 16'({2'd0, piece_ext} * 16'(NUM_AXES)) + {14'd0, i_axis};
    assign pok       = piece_ext < 14'(PIECES);
    assign ok        = pok && (i_axis < 2'(NUM_AXES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_piece <= i_piece;
            r_goal  <= i_goal;
            r_rate  <= i_rate;
            r_el    <= i_elapsed;
            r_idx   <= ok ? idx_full[SLOT_W-1:0] : '0;
            r_ok    <= ok;
            r_pok   <= pok;
        end
    end

    // Slot counter for clearing pass and sweep
    logic [SLOT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Slot memory, one row per piece axis
    t_row              r_mem [SLOTS];
    t_row              r_row;
    t_row              n_wr_row;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sw_rd || i_cmd.cm_rd) begin
            r_row <= r_mem[i_cmd.cm_rd ? r_idx : r_cnt];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= n_wr_row;
        end
    end

    // Step products
    logic [47:0] lprod, rprod, sprod;
    logic [31:0] r_lstep, r_rstep;
    logic [47:0] r_sstep;

    assign lprod = {16'd0, r_row.lin_speed} * {32'd0, r_el};
    assign rprod = {16'd0, r_row.rot_speed} * {32'd0, r_el};
    assign sprod = {16'd0, r_row.spin_ramp} * {32'd0, r_el};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sw_mul) begin
            r_lstep <= lprod[47:16];
            r_rstep <= rprod[47:16];
            r_sstep <= sprod;
        end
    end

    // Approach: linear, turn, spin ramp
    t_row               app_row;
    logic signed [33:0] l_cur, l_goal, l_up, l_dn;
    logic signed [31:0] r_d;
    logic [32:0]        r_ad;
    logic signed [49:0] s_cur, s_goal, s_up, s_dn;

    always_comb begin
        app_row = r_row;
        l_cur   = 34'(r_row.lin_pos);
        l_goal  = 34'(r_row.lin_goal);
        l_up    = l_cur + $signed({2'd0, r_lstep});
        l_dn    = l_cur - $signed({2'd0, r_lstep});
        r_d     = $signed(r_row.rot_goal - r_row.rot_pos);
        r_ad    = r_d[31] ? (33'd0 - {r_d[31], r_d}) : {1'b0, r_d};
        s_cur   = 50'(r_row.spin_now);
        s_goal  = 50'(r_row.spin_goal);
        s_up    = s_cur + $signed({2'd0, r_sstep});
        s_dn    = s_cur - $signed({2'd0, r_sstep});
        // move toward linear goal without passing it
        if (r_row.flags[FLAG_MOVE]) begin
            if (l_cur < l_goal) begin
                app_row.lin_pos = (l_up < l_goal) ? l_up[31:0] : r_row.lin_goal;
            end else begin
                app_row.lin_pos = (l_dn > l_goal) ? l_dn[31:0] : r_row.lin_goal;
            end
            if (app_row.lin_pos == r_row.lin_goal) begin
                app_row.flags[FLAG_MOVE] = 1'b0;
            end
        end
        // shortest wrapped turn; half circle goes negative
        if (r_row.flags[FLAG_TURN]) begin
            if (r_ad <= {1'b0, r_rstep}) begin
                app_row.rot_pos = r_row.rot_goal;
            end else if (!r_d[31]) begin
                app_row.rot_pos = r_row.rot_pos + r_rstep;
            end else begin
                app_row.rot_pos = r_row.rot_pos - r_rstep;
            end
            if (app_row.rot_pos == r_row.rot_goal) begin
                app_row.flags[FLAG_TURN] = 1'b0;
            end
        end
        // ramp spin rate toward its goal
        if ((r_row.spin_ramp != '0) && (r_row.spin_now != r_row.spin_goal)) begin
            if (s_cur < s_goal) begin
                app_row.spin_now = (s_up < s_goal) ? s_up[47:0] : r_row.spin_goal;
            end else begin
                app_row.spin_now = (s_dn > s_goal) ? s_dn[47:0] : r_row.spin_goal;
            end
        end
    end

    t_row r_new;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sw_app) begin
            r_new <= app_row;
        end
    end

    // Spin advance: floor(spin_now * elapsed / 2^32), low 32 bits
    logic signed [64:0] aprod;
    logic [31:0]        r_adv;

    assign aprod = 65'(r_new.spin_now) * 65'($signed({1'b0, r_el}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.sw_adv) begin
            r_adv <= aprod[63:32];
        end
    end

    // Sweep write row and motion tally
    t_row sw_row;
    logic slot_still;
    logic r_still;
    logic r_pending;

    always_comb begin
        sw_row         = r_new;
        sw_row.rot_pos = r_new.rot_pos + r_adv;
        slot_still     = (r_new.flags != 2'd0) || (r_new.spin_now != '0) ||
                         ((r_new.spin_ramp != '0) && (r_new.spin_now != r_new.spin_goal));
    end

    // Command execute
    t_row ex_row;
    logic ex_wr;
    logic ex_pend;

    always_comb begin
        ex_row  = r_row;
        ex_wr   = 1'b0;
        ex_pend = 1'b0;
        case (r_mode)
            MODE_MOVE, MODE_MOVE_NOW: begin
                ex_wr = 1'b1;
                if ((r_mode == MODE_MOVE_NOW) || (r_rate <= 0)) begin
                    ex_row.lin_pos          = r_goal;
                    ex_row.flags[FLAG_MOVE] = 1'b0;
                end else begin
                    ex_row.lin_goal         = r_goal;
                    ex_row.lin_speed        = r_rate;
                    ex_row.flags[FLAG_MOVE] = 1'b1;
                    ex_pend                 = 1'b1;
                end
            end
            MODE_TURN, MODE_TURN_NOW: begin
                ex_wr = 1'b1;
                if ((r_mode == MODE_TURN_NOW) || (r_rate <= 0)) begin
                    ex_row.rot_pos          = r_goal;
                    ex_row.flags[FLAG_TURN] = 1'b0;
                end else begin
                    ex_row.rot_goal         = r_goal;
                    ex_row.rot_speed        = r_rate;
                    ex_row.flags[FLAG_TURN] = 1'b1;
                    ex_pend                 = 1'b1;
                end
            end
            MODE_SPIN, MODE_STOP_SPIN: begin
                ex_wr            = 1'b1;
                ex_pend          = 1'b1;
                ex_row.spin_goal = (r_mode == MODE_SPIN) ? {r_goal, 16'd0} : '0;
                ex_row.spin_ramp = r_rate[31] ? (32'd0 - r_rate) : r_rate;
                if (r_rate == 0) begin
                    ex_row.spin_now = ex_row.spin_goal;
                end
            end
            default: begin
                ex_wr = 1'b0;
            end
        endcase
    end

    // Write port select
    always_comb begin
        wr_en    = i_cmd.clr_wr || i_cmd.sw_wr || (i_cmd.cm_ex && ex_wr && r_ok);
        wr_addr  = i_cmd.cm_ex ? r_idx : r_cnt;
        n_wr_row = '0;
        if (i_cmd.sw_wr) begin
            n_wr_row = sw_row;
        end else if (i_cmd.cm_ex) begin
            n_wr_row = ex_row;
        end
    end

    // Motion pending flag
    logic n_pending;

    assign n_pending = r_pending || (ex_pend && r_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still   <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            if (i_cmd.still_clr) begin
                r_still <= 1'b0;
            end else if (i_cmd.sw_wr) begin
                r_still <= r_still || slot_still;
            end
            if (i_cmd.pend_upd) begin
                r_pending <= r_still || slot_still;
            end else if (i_cmd.cm_ex) begin
                r_pending <= n_pending;
            end
        end
    end

    // Visibility flags
    logic [PIECES-1:0] r_shown;
    logic [13:0]       rp_ext;
    logic [PIDX_W-1:0] pidx;
    logic              n_shown;

    assign rp_ext = {8'd0, r_piece};
    assign pidx   = rp_ext[PIDX_W-1:0];

    always_comb begin
        n_shown = r_shown[pidx];
        case (r_mode)
            MODE_SHOW: n_shown = 1'b1;
            MODE_HIDE: n_shown = 1'b0;
            default:   n_shown = r_shown[pidx];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= '0;
        end else if (i_cmd.cm_ex && r_pok) begin
            r_shown[pidx] <= n_shown;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.cm_ex) begin
            o_position   <= r_ok ? ex_row.lin_pos : '0;
            o_angle      <= r_ok ? ex_row.rot_pos : '0;
            o_moving     <= r_ok && ex_row.flags[FLAG_MOVE];
            o_turning    <= r_ok && ex_row.flags[FLAG_TURN];
            o_shown      <= r_pok && n_shown;
            o_any_motion <= n_pending;
        end
    end

    assign o_sts.is_tick = (r_mode == MODE_TICK);
    assign o_sts.pending = r_pending;
    assign o_sts.last    = (r_cnt == SLOT_W'(SLOTS - 1));

endmodule

`default_nettype wire

FILE: sv/piece_motion_animator.sv
// ----------------------------------------------------------------------------
// piece_motion_animator
// Per-piece, per-axis motion state with move, turn, spin, show/hide and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per beat (mode, piece, axis, goal, rate, elapsed);
//   o_out returns exactly one result beat per item: the addressed piece
//   axis state after the item, plus the motion-pending flag.
//   A command or read goes through dispatch, slot read and execute.
//   A tick with motion pending sweeps every piece axis through one shared
//   multiply/approach unit, slot by slot in read, multiply, approach,
//   advance and write steps; the slot memory's single read port and the
//   dependent ramp-then-advance multiplies set this step order.
//   One item is in flight at a time; i_in.ready rises again once the
//   result beat has been taken.
//   After reset a clearing pass writes every slot to zero, during which
//   no item is accepted.
//   If the receiver stalls, the result is held in its register and no new
//   item is accepted until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module piece_motion_animator
    import pma_pkg::*;
#(
    parameter int PIECES = PIECES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pma_in_if.sink    i_in,
    pma_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    pma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    pma_dp #(
        .PIECES (PIECES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_in.mode),
        .i_piece      (i_in.piece),
        .i_axis       (i_in.axis),
        .i_goal       (i_in.goal),
        .i_rate       (i_in.rate),
        .i_elapsed    (i_in.elapsed),
        .o_sts        (sts),
        .o_position   (o_out.position),
        .o_angle      (o_out.angle),
        .o_moving     (o_out.moving),
        .o_turning    (o_out.turning),
        .o_shown      (o_out.shown),
        .o_any_motion (o_out.any_motion)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    // One item in flight: no input beat while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while result pending");

    // Accepted beat closes the input side next cycle
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready straight after accept");

    // A taken result is not repeated
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> !o_out.valid)
        else $error("result repeated");

endmodule

`default_nettype wire

FILE: sim/tb_piece_motion_animator.sv
// ----------------------------------------------------------------------------
// tb_piece_motion_animator
// Self-checking bench: directed and random items go in over the item channel.
// A scoreboard keeps its own copy of every piece axis, works out each
// expected result beat and compares it with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_piece_motion_animator;
    import pma_pkg::*;

    localparam logic [3:0] MODE_READ = 4'd9;
    localparam int SLOT_COUNT = PIECES_DEF * NUM_AXES;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic signed [31:0] position;
        logic [31:0]        angle;
        logic               moving;
        logic               turning;
        logic               shown;
        logic               any_motion;
    } t_axis_view;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the motion state and the pending result beats
    // ------------------------------------------------------------------------
    class motion_scoreboard;
        logic signed [31:0] lin_pos [SLOT_COUNT];
        logic signed [31:0] lin_goal [SLOT_COUNT];
        logic [31:0]        lin_speed [SLOT_COUNT];
        logic [31:0]        rot_pos [SLOT_COUNT];
        logic [31:0]        rot_goal [SLOT_COUNT];
        logic [31:0]        rot_speed [SLOT_COUNT];
        longint             spin_now [SLOT_COUNT];
        longint             spin_goal [SLOT_COUNT];
        logic [31:0]        spin_ramp [SLOT_COUNT];
        logic [1:0]         flags [SLOT_COUNT];
        logic               shown [PIECES_DEF];
        logic               pending;
        t_axis_view         views_due [$];
        int                 errors;
        int                 checked;

        function new();
            for (int s = 0; s < SLOT_COUNT; s++) begin
                lin_pos[s] = 0; lin_goal[s] = 0; lin_speed[s] = 0;
                rot_pos[s] = 0; rot_goal[s] = 0; rot_speed[s] = 0;
                spin_now[s] = 0; spin_goal[s] = 0; spin_ramp[s] = 0;
                flags[s] = 0;
            end
            foreach (shown[p]) shown[p] = 0;
            pending = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint step_toward(longint cur, longint tgt, longint stp);
            if (cur < tgt) return (cur + stp < tgt) ? cur + stp : tgt;
            return (cur - stp > tgt) ? cur - stp : tgt;
        endfunction

        // Advance every piece axis by one tick of el
        function void advance_all(logic [15:0] el);
            logic [63:0] prod;
            longint stp, delta, adist, adv;
            logic still;
            still = 0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (flags[s][FLAG_MOVE]) begin
                    prod = {32'b0, lin_speed[s]} * {48'b0, el};
                    stp = longint'(prod >> 16);
                    lin_pos[s] = 32'(step_toward(lin_pos[s], lin_goal[s], stp));
                    if (lin_pos[s] == lin_goal[s]) flags[s][FLAG_MOVE] = 0;
                end
                if (flags[s][FLAG_TURN]) begin
                    prod = {32'b0, rot_speed[s]} * {48'b0, el};
                    stp = longint'(prod >> 16);
                    delta = longint'(signed'(rot_goal[s] - rot_pos[s]));
                    adist = delta < 0 ? -delta : delta;
                    if (adist <= stp) rot_pos[s] = rot_goal[s];
                    else if (delta > 0) rot_pos[s] = rot_pos[s] + stp[31:0];
                    else rot_pos[s] = rot_pos[s] - stp[31:0];
                    if (rot_pos[s] == rot_goal[s]) flags[s][FLAG_TURN] = 0;
                end
                if (spin_ramp[s] != 0 && spin_now[s] != spin_goal[s])
                    spin_now[s] = step_toward(spin_now[s], spin_goal[s],
                                              longint'(spin_ramp[s]) * longint'(el));
                adv = (spin_now[s] * longint'(el)) >>> 32;
                rot_pos[s] = rot_pos[s] + adv[31:0];
                if (flags[s] != 0 || spin_now[s] != 0 ||
                    (spin_ramp[s] != 0 && spin_now[s] != spin_goal[s]))
                    still = 1;
            end
            pending = still;
        endfunction

        // Apply one accepted item and queue the result beat it must cause
        function void note_item(logic [3:0] mode, logic [5:0] piece, logic [1:0] axis,
                                logic signed [31:0] goal, logic signed [31:0] rate,
                                logic [15:0] el);
            logic ok;
            int s;
            longint r;
            t_axis_view v;
            ok = (piece < PIECES_DEF) && (axis < NUM_AXES);
            s = ok ? piece * NUM_AXES + axis : 0;
            r = longint'(rate);
            case (mode)
                MODE_TICK: if (pending) advance_all(el);
                MODE_MOVE, MODE_MOVE_NOW: if (ok) begin
                    if (mode == MODE_MOVE_NOW || rate <= 0) begin
                        lin_pos[s] = goal;
                        flags[s][FLAG_MOVE] = 0;
                    end else begin
                        lin_goal[s] = goal;
                        lin_speed[s] = rate;
                        flags[s][FLAG_MOVE] = 1;
                        pending = 1;
                    end
                end
                MODE_TURN, MODE_TURN_NOW: if (ok) begin
                    if (mode == MODE_TURN_NOW || rate <= 0) begin
                        rot_pos[s] = goal;
                        flags[s][FLAG_TURN] = 0;
                    end else begin
                        rot_goal[s] = goal;
                        rot_speed[s] = rate;
                        flags[s][FLAG_TURN] = 1;
                        pending = 1;
                    end
                end
                MODE_SPIN, MODE_STOP_SPIN: if (ok) begin
                    spin_goal[s] = (mode == MODE_SPIN) ? longint'(goal) * 65536 : 0;
                    spin_ramp[s] = 32'(r < 0 ? -r : r);
                    if (rate == 0) spin_now[s] = spin_goal[s];
                    pending = 1;
                end
                MODE_SHOW: if (piece < PIECES_DEF) shown[piece] = 1;
                MODE_HIDE: if (piece < PIECES_DEF) shown[piece] = 0;
                default: ;
            endcase
            v.position   = ok ? lin_pos[s] : 0;
            v.angle      = ok ? rot_pos[s] : 0;
            v.moving     = ok ? flags[s][FLAG_MOVE] : 0;
            v.turning    = ok ? flags[s][FLAG_TURN] : 0;
            v.shown      = (piece < PIECES_DEF) ? shown[piece] : 0;
            v.any_motion = pending;
            views_due = {views_due, v};
        endfunction

        task report(string what);
            $display("%0t ERROR: %s", $realtime, what);
            errors++;
        endtask

        // Compare one result beat with the oldest expectation
        task check_result(t_axis_view got);
            t_axis_view w;
            if (views_due.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            w = views_due.pop_front();
            checked++;
            if (got.position !== w.position)
                report($sformatf("position %h, want %h", got.position, w.position));
            if (got.angle !== w.angle)
                report($sformatf("angle %h, want %h", got.angle, w.angle));
            if (got.moving !== w.moving)
                report($sformatf("moving %b, want %b", got.moving, w.moving));
            if (got.turning !== w.turning)
                report($sformatf("turning %b, want %b", got.turning, w.turning));
            if (got.shown !== w.shown)
                report($sformatf("shown %b, want %b", got.shown, w.shown));
            if (got.any_motion !== w.any_motion)
                report($sformatf("any_motion %b, want %b", got.any_motion, w.any_motion));
        endtask
    endclass

    logic clk;
    logic rst_n;
    pma_in_if  in_if ();
    pma_out_if out_if ();

    piece_motion_animator u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    motion_scoreboard board = new();
    int  mode_hits [16];
    int  hold_asked = 0;
    int  hold_taken = 0;
    int  stall_left = 0;
    bit  quiet = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Watch both channels at each edge
    always @(posedge clk) begin
        t_axis_view got;
        if (rst_n && in_if.valid && in_if.ready) begin
            board.note_item(in_if.mode, in_if.piece, in_if.axis, in_if.goal,
                            in_if.rate, in_if.elapsed);
            mode_hits[in_if.mode]++;
        end
        if (rst_n && out_if.valid && out_if.ready) begin
            got.position   = out_if.position;
            got.angle      = out_if.angle;
            got.moving     = out_if.moving;
            got.turning    = out_if.turning;
            got.shown      = out_if.shown;
            got.any_motion = out_if.any_motion;
            board.check_result(got);
        end
    end

    // Result side: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            stall_left <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            out_if.ready <= 1'b1;
        end
    end

    // Offer one beat, wait until it is taken
    task automatic send_item(logic [3:0] mode, logic [5:0] piece, logic [1:0] axis,
                             logic [31:0] goal, logic [31:0] rate, logic [15:0] el);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.mode    <= mode;
        in_if.piece   <= piece;
        in_if.axis    <= axis;
        in_if.goal    <= goal;
        in_if.rate    <= rate;
        in_if.elapsed <= el;
        do @(posedge clk); while (!in_if.ready);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (board.views_due.size() != 0) @(posedge clk);
    endtask

    // Random item, biased towards a few pieces so motions interact
    task automatic send_random();
        logic [3:0]  mode;
        logic [5:0]  piece;
        logic [1:0]  axis;
        logic [31:0] goal, rate;
        int r;
        r = $urandom_range(0, 99);
        if (r < 16) mode = MODE_TICK;
        else if (r < 90) mode = 4'($urandom_range(MODE_MOVE, MODE_READ));
        else mode = 4'($urandom_range(0, 15));
        piece = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
        axis  = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0: goal = $urandom;
            1: goal = 32'($urandom_range(0, 4000000)) - 32'd2000000;
            2: goal = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
            default: goal = 32'($urandom_range(0, 65536)) - 32'd32768;
        endcase
        if (mode == MODE_SPIN && $urandom_range(0, 2) != 0)
            goal = 32'($urandom_range(0, 2000)) - 32'd1000;
        case ($urandom_range(0, 7))
            0: rate = $urandom;
            1: rate = 32'd0;
            2: rate = -32'($urandom_range(1, 1000000));
            default: rate = 32'($urandom_range(1, 32'h0400_0000));
        endcase
        send_item(mode, piece, axis, goal, rate, 16'($urandom));
    endtask

    initial begin
        rst_n = 1'b0;
        in_if.valid <= 1'b0;
        in_if.mode <= MODE_READ;
        in_if.piece <= '0;
        in_if.axis <= '0;
        in_if.goal <= '0;
        in_if.rate <= '0;
        in_if.elapsed <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, visibility, extremes, bad address, spare modes
        send_item(MODE_TICK, 0, 0, 0, 0, 16'hFFFF);
        send_item(MODE_SHOW, 63, 3, 0, 0, 0);
        send_item(MODE_SHOW, 0, 0, 0, 0, 0);
        send_item(MODE_HIDE, 63, 0, 0, 0, 0);
        send_item(MODE_MOVE_NOW, 63, 2, 32'h7FFF_FFFF, 0, 0);
        send_item(MODE_MOVE, 1, 1, 32'h8000_0000, 0, 0);
        send_item(MODE_MOVE, 1, 2, 32'h1234_5678, 32'h8000_0000, 0);
        send_item(MODE_MOVE, 2, 3, 32'h0001_0000, 32'h0001_0000, 0);
        send_item(MODE_READ, 2, 3, 0, 0, 0);
        send_item(4'd10, 1, 1, 0, 0, 0);
        send_item(4'd15, 63, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        // Half-circle turn goes the negative way
        send_item(MODE_TURN, 3, 0, 32'h8000_0000, 32'h0100_0000, 0);
        send_item(MODE_TURN_NOW, 3, 1, 32'hFFFF_FFFF, 0, 0);
        send_item(MODE_MOVE, 3, 2, 32'h0002_0000, 32'h7FFF_FFFF, 0);
        send_item(MODE_SPIN, 4, 0, 32'd1000, 0, 0);
        send_item(MODE_SPIN, 4, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_item(MODE_TICK, 0, 0, 0, 0, 16'h8000);
        send_item(MODE_TICK, 3, 0, 0, 0, 16'hFFFF);
        send_item(MODE_STOP_SPIN, 4, 0, 0, 32'hFFFF_FFFF, 0);
        send_item(MODE_STOP_SPIN, 4, 1, 0, 0, 0);
        send_item(MODE_TICK, 4, 0, 0, 0, 16'h0001);
        send_item(MODE_READ, 3, 0, 0, 0, 0);
        wait_drained();

        // Random part with a long result hold-off and a full drain inside
        for (int n = 0; n < 1600; n++) begin
            if (n == 400) begin
                hold_asked = hold_asked + 1;
            end
            if (n == 800) begin
                wait_drained();
            end
            quiet = (n >= 1000 && n < 1150);
            send_random();
        end
        in_if.valid <= 1'b0;
        quiet = 0;
        wait_drained();
        repeat (1100) @(posedge clk);

        $display("Covered %0d result beats: %0d ticks, %0d moves, %0d turns, %0d spins,",
                 board.checked, mode_hits[MODE_TICK],
                 mode_hits[MODE_MOVE] + mode_hits[MODE_MOVE_NOW],
                 mode_hits[MODE_TURN] + mode_hits[MODE_TURN_NOW],
                 mode_hits[MODE_SPIN] + mode_hits[MODE_STOP_SPIN]);
        $display("plus show/hide, reads, spare modes, bad axes and one long output stall.");
        if (board.errors == 0 && board.views_due.size() == 0) begin
            $display("piece_motion_animator verification clean");
        end else begin
            if (board.views_due.size() != 0)
                board.report($sformatf("%0d results never arrived", board.views_due.size()));
            $display("piece_motion_animator verification failed");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #100ms;
        $display("piece_motion_animator verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/pma_pkg.sv
sv/pma_if.sv
sv/pma_ctrl.sv
sv/pma_dp.sv
sv/piece_motion_animator.sv
sim/tb_piece_motion_animator.sv
